// ----- src/riemann_tensor_component_unit_macros.svh -----
`ifndef RIEMANN_TENSOR_COMPONENT_UNIT_MACROS_SVH
`define RIEMANN_TENSOR_COMPONENT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rtc_pkg.sv -----
package rtc_pkg;

    localparam int DIMS        = 4;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = 2;
    localparam int DATA_W      = 32;
    localparam int INV_W       = 31;
    localparam int PROD_W      = 2 * (DATA_W + 1);
    localparam int TERM_W      = PROD_W - FRAC_BITS;
    localparam int ACC_W       = TERM_W + 4;
    localparam int BASE_AW     = 3 * IDX_W;
    localparam int SHIFT_AW    = 4 * IDX_W;
    localparam int BASE_DEPTH  = 1 << BASE_AW;
    localparam int SHIFT_DEPTH = 1 << SHIFT_AW;
    localparam int LAM_W       = $clog2(DIMS + 1);
    localparam int PC_W        = 4;

    localparam logic [INV_W-1:0]         INV_RESET = INV_W'(64'd1 << FRAC_BITS);
    localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(64'd1 << (FRAC_BITS - 1));

    localparam logic [PC_W-1:0] PC_ENTRY = PC_W'(0);
    localparam logic [PC_W-1:0] PC_LOOP  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_LAST  = PC_W'(9);

    typedef enum logic [1:0] {
        KIND_BASE,
        KIND_PLUS,
        KIND_MINUS,
        KIND_QUERY
    } t_kind;

    // Shifted-table read: derivative along mu or along nu.
    typedef enum logic {
        DIR_MU,
        DIR_NU
    } t_dir_sel;

    // Base-table read for one lambda: X1 = (rho,mu,l), Y1 = (l,nu,sigma),
    // X2 = (rho,nu,l), Y2 = (l,mu,sigma).
    typedef enum logic [1:0] {
        BSEL_X1,
        BSEL_Y1,
        BSEL_X2,
        BSEL_Y2
    } t_base_sel;

    typedef enum logic [1:0] {
        HOLD_KEEP,
        HOLD_DIFF,
        HOLD_BASE
    } t_hold_op;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_INV,
        MUL_BASE
    } t_mul_op;

    typedef enum logic [1:0] {
        ACC_KEEP,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef enum logic {
        LAM_KEEP,
        LAM_INC
    } t_lam_op;

    typedef enum logic {
        COND_NONE,
        COND_LOOP
    } t_cond;

    typedef struct packed {
        logic              shift_rd;
        t_dir_sel          dir_sel;
        logic              base_rd;
        t_base_sel         base_sel;
        t_hold_op          hold_op;
        t_mul_op           mul_op;
        t_acc_op           acc_op;
        t_lam_op           lam_op;
        t_cond             cond;
        logic [PC_W-1:0]   target;
        logic              last;
    } t_ctrl;

    typedef struct packed {
        logic             active;
        t_ctrl            word;
        logic [IDX_W-1:0] lam;
    } t_seq_ctl;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  shift_dir;
        logic [IDX_W-1:0]  idx_a;
        logic [IDX_W-1:0]  idx_b;
        logic [IDX_W-1:0]  idx_c;
        logic [IDX_W-1:0]  idx_d;
        logic [DATA_W-1:0] entry_value;
    } t_item;

    localparam t_ctrl CTRL_NOP = '{
        shift_rd: 1'b0,
        dir_sel:  DIR_MU,
        base_rd:  1'b0,
        base_sel: BSEL_X1,
        hold_op:  HOLD_KEEP,
        mul_op:   MUL_NONE,
        acc_op:   ACC_KEEP,
        lam_op:   LAM_KEEP,
        cond:     COND_NONE,
        target:   PC_ENTRY,
        last:     1'b0
    };

    function automatic logic idx_ok(input logic [IDX_W-1:0] x);
        return (int'(x) < DIMS);
    endfunction

    // Microprogram for one query. Each table read lands in the next cycle; the
    // multiplier writes a rounded term that the accumulator takes in the next cycle.
    function automatic t_ctrl prog_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = CTRL_NOP;
        case (pc)
            PC_W'(0): begin
                w.shift_rd = 1'b1;
                w.dir_sel  = DIR_MU;
            end
            PC_W'(1): begin
                w.shift_rd = 1'b1;
                w.dir_sel  = DIR_NU;
                w.hold_op  = HOLD_DIFF;
            end
            PC_W'(2): begin
                w.hold_op = HOLD_DIFF;
                w.mul_op  = MUL_INV;
            end
            PC_W'(3): begin
                w.base_rd  = 1'b1;
                w.base_sel = BSEL_X1;
                w.acc_op   = ACC_ADD;
                w.mul_op   = MUL_INV;
            end
            PC_LOOP: begin
                w.base_rd  = 1'b1;
                w.base_sel = BSEL_Y1;
                w.acc_op   = ACC_SUB;
                w.hold_op  = HOLD_BASE;
            end
            PC_W'(5): begin
                w.base_rd  = 1'b1;
                w.base_sel = BSEL_X2;
                w.mul_op   = MUL_BASE;
            end
            PC_W'(6): begin
                w.base_rd  = 1'b1;
                w.base_sel = BSEL_Y2;
                w.hold_op  = HOLD_BASE;
                w.acc_op   = ACC_ADD;
                w.lam_op   = LAM_INC;
            end
            PC_W'(7): begin
                w.base_rd  = 1'b1;
                w.base_sel = BSEL_X1;
                w.mul_op   = MUL_BASE;
                w.cond     = COND_LOOP;
                w.target   = PC_LOOP;
            end
            PC_W'(8): begin
                w.acc_op = ACC_SUB;
            end
            PC_LAST: begin
                w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- src/rtc_ifs.sv -----
interface rtc_item_if;
    import rtc_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [IDX_W-1:0]  shift_dir;
    logic [IDX_W-1:0]  idx_a;
    logic [IDX_W-1:0]  idx_b;
    logic [IDX_W-1:0]  idx_c;
    logic [IDX_W-1:0]  idx_d;
    logic [DATA_W-1:0] entry_value;

    modport source (
        output valid, kind, shift_dir, idx_a, idx_b, idx_c, idx_d, entry_value,
        input  ready
    );
    modport sink (
        input  valid, kind, shift_dir, idx_a, idx_b, idx_c, idx_d, entry_value,
        output ready
    );
endinterface

interface rtc_result_if;
    import rtc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] component;
    logic              saturated;

    modport source (
        output valid, component, saturated,
        input  ready
    );
    modport sink (
        input  valid, component, saturated,
        output ready
    );
endinterface

interface rtc_cfg_if;
    import rtc_pkg::*;

    logic             valid;
    logic             ready;
    logic [INV_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// ----- src/riemann_tensor_component_unit.sv -----
// Riemann component unit. Load beats (kind 0, 1, 2) write one Christoffel entry into the base,
// plus-shifted or minus-shifted table in the cycle they are accepted and return nothing. A query
// beat (kind 3) names rho, sigma, mu and nu and returns one saturated Q16.16 component with a
// saturation flag. A short microprogram drives one multiplier and one accumulator, and the sixteen
// base-table entries per query are read through that table's single read port four to a lambda,
// four lambdas in turn. A query with an index out of range answers zero. The input is not ready
// while a query runs; a finished result waits in the output register, and a new beat is accepted
// then. inv_two_h is written through the configuration channel, which is always ready.
`include "riemann_tensor_component_unit_macros.svh"

module riemann_tensor_component_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rtc_item_if.sink     i_item,
    rtc_result_if.source o_result,
    rtc_cfg_if.sink      i_cfg
);
    import rtc_pkg::*;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    logic [INV_W-1:0]        r_inv;
    logic                    r_out_valid;
    logic [DATA_W-1:0]       r_comp;
    logic                    r_sat;

    t_item                   w_item;
    t_seq_ctl                w_ctl;
    logic                    w_busy;
    logic                    w_take;
    logic                    w_query;
    logic                    w_bad;
    logic                    w_stall;
    logic                    w_finish;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_fits;
    logic [DATA_W-1:0]       w_comp;

    assign w_item.kind        = t_kind'(i_item.kind);
    assign w_item.shift_dir   = i_item.shift_dir;
    assign w_item.idx_a       = i_item.idx_a;
    assign w_item.idx_b       = i_item.idx_b;
    assign w_item.idx_c       = i_item.idx_c;
    assign w_item.idx_d       = i_item.idx_d;
    assign w_item.entry_value = i_item.entry_value;

    assign i_item.ready = !w_busy;
    assign i_cfg.ready  = 1'b1;

    assign w_take   = i_item.valid && !w_busy;
    assign w_query  = w_take && w_item.kind == KIND_QUERY;
    assign w_bad    = !(idx_ok(w_item.idx_a) && idx_ok(w_item.idx_b)
                        && idx_ok(w_item.idx_c) && idx_ok(w_item.idx_d));
    assign w_stall  = r_out_valid && !o_result.ready;
    assign w_finish = w_ctl.active && w_ctl.word.last && !w_stall;

    rtc_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_query),
        .i_start_pc (w_bad ? PC_LAST : PC_ENTRY),
        .i_stall    (w_stall),
        .o_ctl      (w_ctl),
        .o_busy     (w_busy)
    );

    rtc_datapath u_dp (
        .i_clk       (i_clk),
        .i_take      (w_take),
        .i_item      (w_item),
        .i_ctl       (w_ctl),
        .i_inv_two_h (r_inv),
        .o_acc       (w_acc)
    );

    assign w_fits = (&w_acc[ACC_W-1:DATA_W-1]) || !(|w_acc[ACC_W-1:DATA_W-1]);
    assign w_comp = w_fits ? w_acc[DATA_W-1:0]
                           : (w_acc[ACC_W-1] ? SAT_MIN : SAT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv       <= INV_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_inv <= i_cfg.data;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_comp <= w_comp;
            r_sat  <= !w_fits;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.component = r_comp;
    assign o_result.saturated = r_sat;

    `RTC_ASSERT_NEXT(a_query_starts, i_clk, i_rst_n, w_query, w_busy, "query beat did not start the sequencer")
    `RTC_ASSERT_NEXT(a_load_no_run, i_clk, i_rst_n, w_take && !w_query, !w_busy, "load beat started the sequencer")
    `RTC_ASSERT_SAME(a_sat_value, i_clk, i_rst_n, r_out_valid && r_sat, r_comp == SAT_MAX || r_comp == SAT_MIN, "saturated result is not a range limit")

endmodule

// ----- src/rtc_sequencer.sv -----
module rtc_sequencer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rtc_pkg::PC_W-1:0] i_start_pc,
    input  logic                     i_stall,
    output rtc_pkg::t_seq_ctl        o_ctl,
    output logic                     o_busy
);
    import rtc_pkg::*;

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } t_state;

    t_state           r_state, n_state;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic [LAM_W-1:0] r_lam, n_lam;
    t_ctrl            w_word;

    always_comb begin
        w_word  = prog_word(r_pc);
        n_state = r_state;
        n_pc    = r_pc;
        n_lam   = r_lam;
        case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    n_state = SQ_RUN;
                    n_pc    = i_start_pc;
                    n_lam   = '0;
                end
            end
            SQ_RUN: begin
                if (w_word.lam_op == LAM_INC) begin
                    n_lam = r_lam + LAM_W'(1);
                end
                if (w_word.last) begin
                    if (!i_stall) begin
                        n_state = SQ_IDLE;
                    end
                end else if (w_word.cond == COND_LOOP && r_lam != LAM_W'(DIMS)) begin
                    n_pc = w_word.target;
                end else begin
                    n_pc = r_pc + PC_W'(1);
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_pc    <= PC_ENTRY;
            r_lam   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_lam   <= n_lam;
        end
    end

    assign o_busy       = (r_state == SQ_RUN);
    assign o_ctl.active = o_busy;
    assign o_ctl.word   = o_busy ? w_word : CTRL_NOP;
    assign o_ctl.lam    = r_lam[IDX_W-1:0];

endmodule

// ----- src/rtc_datapath.sv -----
module rtc_datapath (
    input  logic                               i_clk,
    input  logic                               i_take,
    input  rtc_pkg::t_item                     i_item,
    input  rtc_pkg::t_seq_ctl                  i_ctl,
    input  logic [rtc_pkg::INV_W-1:0]          i_inv_two_h,
    output logic signed [rtc_pkg::ACC_W-1:0]   o_acc
);
    import rtc_pkg::*;

    logic [DATA_W-1:0] r_base_mem  [BASE_DEPTH];
    logic [DATA_W-1:0] r_plus_mem  [SHIFT_DEPTH];
    logic [DATA_W-1:0] r_minus_mem [SHIFT_DEPTH];

    logic [DATA_W-1:0] r_base_q;
    logic [DATA_W-1:0] r_plus_q;
    logic [DATA_W-1:0] r_minus_q;

    logic [IDX_W-1:0] r_rho, r_sigma, r_mu, r_nu;

    logic signed [DATA_W:0]   r_hold;
    logic signed [TERM_W-1:0] r_term;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     w_load_ok;
    logic                     w_base_we, w_plus_we, w_minus_we;
    logic                     w_query;
    logic [BASE_AW-1:0]       w_base_waddr, w_base_raddr;
    logic [SHIFT_AW-1:0]      w_shift_waddr, w_shift_raddr;
    logic signed [DATA_W:0]   w_base_ext, w_diff, w_mul_b;
    logic signed [PROD_W-1:0] w_prod, w_rnd, w_term_full;
    logic signed [ACC_W-1:0]  w_term_ext;

    assign w_load_ok = idx_ok(i_item.idx_a) && idx_ok(i_item.idx_b)
                       && idx_ok(i_item.idx_c);
    assign w_base_we  = i_take && i_item.kind == KIND_BASE && w_load_ok;
    assign w_plus_we  = i_take && i_item.kind == KIND_PLUS && w_load_ok
                        && idx_ok(i_item.shift_dir);
    assign w_minus_we = i_take && i_item.kind == KIND_MINUS && w_load_ok
                        && idx_ok(i_item.shift_dir);
    assign w_query    = i_take && i_item.kind == KIND_QUERY;

    assign w_base_waddr  = {i_item.idx_a, i_item.idx_b, i_item.idx_c};
    assign w_shift_waddr = {i_item.shift_dir, i_item.idx_a, i_item.idx_b, i_item.idx_c};

    always_comb begin
        case (i_ctl.word.dir_sel)
            DIR_MU:  w_shift_raddr = {r_mu, r_rho, r_nu, r_sigma};
            DIR_NU:  w_shift_raddr = {r_nu, r_rho, r_mu, r_sigma};
            default: w_shift_raddr = {r_mu, r_rho, r_nu, r_sigma};
        endcase
        case (i_ctl.word.base_sel)
            BSEL_X1: w_base_raddr = {r_rho, r_mu, i_ctl.lam};
            BSEL_Y1: w_base_raddr = {i_ctl.lam, r_nu, r_sigma};
            BSEL_X2: w_base_raddr = {r_rho, r_nu, i_ctl.lam};
            BSEL_Y2: w_base_raddr = {i_ctl.lam, r_mu, r_sigma};
            default: w_base_raddr = {r_rho, r_mu, i_ctl.lam};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_base_we) begin
            r_base_mem[w_base_waddr] <= i_item.entry_value;
        end
        if (i_ctl.word.base_rd) begin
            r_base_q <= r_base_mem[w_base_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_plus_we) begin
            r_plus_mem[w_shift_waddr] <= i_item.entry_value;
        end
        if (i_ctl.word.shift_rd) begin
            r_plus_q <= r_plus_mem[w_shift_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_minus_we) begin
            r_minus_mem[w_shift_waddr] <= i_item.entry_value;
        end
        if (i_ctl.word.shift_rd) begin
            r_minus_q <= r_minus_mem[w_shift_raddr];
        end
    end

    assign w_base_ext = $signed({r_base_q[DATA_W-1], r_base_q});
    assign w_diff     = $signed({r_plus_q[DATA_W-1], r_plus_q})
                        - $signed({r_minus_q[DATA_W-1], r_minus_q});

    always_comb begin
        case (i_ctl.word.mul_op)
            MUL_INV: w_mul_b = $signed({{(DATA_W + 1 - INV_W){1'b0}}, i_inv_two_h});
            default: w_mul_b = w_base_ext;
        endcase
    end

    assign w_prod      = r_hold * w_mul_b;
    assign w_rnd       = w_prod + RND_HALF;
    assign w_term_full = w_rnd >>> FRAC_BITS;
    assign w_term_ext  = {{(ACC_W - TERM_W){r_term[TERM_W-1]}}, r_term};

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_rho   <= i_item.idx_a;
            r_sigma <= i_item.idx_b;
            r_mu    <= i_item.idx_c;
            r_nu    <= i_item.idx_d;
        end
        case (i_ctl.word.hold_op)
            HOLD_DIFF: r_hold <= w_diff;
            HOLD_BASE: r_hold <= w_base_ext;
            default:   r_hold <= r_hold;
        endcase
        if (i_ctl.word.mul_op != MUL_NONE) begin
            r_term <= $signed(w_term_full[TERM_W-1:0]);
        end
        if (w_query) begin
            r_acc <= '0;
        end else begin
            case (i_ctl.word.acc_op)
                ACC_ADD: r_acc <= r_acc + w_term_ext;
                ACC_SUB: r_acc <= r_acc - w_term_ext;
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- test/riemann_tensor_component_unit_test.sv -----
`timescale 1ns / 1ps

module riemann_tensor_component_unit_test;
    import rtc_pkg::*;

    localparam int     ITEMS_PER_PHASE = 230;
    localparam int     SETTLE_CYCLES   = 40;
    localparam int     HOLD_CYCLES     = 400;
    localparam int     MAX_REPORTS     = 50;
    localparam longint RUN_LIMIT_NS    = 8_000_000;
    localparam longint Q_MAX           = 64'sd2147483647;
    localparam longint Q_MIN           = -64'sd2147483648;

    typedef enum logic [1:0] {
        VAL_MIX,
        VAL_MAX,
        VAL_MIN
    } t_fill;

    typedef struct packed {
        logic [DATA_W-1:0] component;
        logic              saturated;
    } t_component;

    logic clk;
    logic rst_n;

    rtc_item_if   item_if();
    rtc_result_if result_if();
    rtc_cfg_if    cfg_if();

    riemann_tensor_component_unit u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if.sink),
        .o_result (result_if.source),
        .i_cfg    (cfg_if.sink)
    );

    logic signed [DATA_W-1:0] base_tab  [BASE_DEPTH];
    logic signed [DATA_W-1:0] plus_tab  [SHIFT_DEPTH];
    logic signed [DATA_W-1:0] minus_tab [SHIFT_DEPTH];
    logic [INV_W-1:0]         inv_reg;

    bit base_set  [BASE_DEPTH];
    bit plus_set  [SHIFT_DEPTH];
    bit minus_set [SHIFT_DEPTH];

    t_item      pending_items[$];
    t_item      offered;
    t_component expected_components[$];

    int errors;
    int items_queued;
    int src_gap;
    int sink_gap;
    int hold_left;
    bit hold_req;
    bit src_steady;
    bit sink_steady;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("riemann_tensor_component_unit_test NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (errors < MAX_REPORTS) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(input t_fill mode);
        int r;
        if (mode == VAL_MAX) begin
            return 32'h7FFF_FFFF;
        end
        if (mode == VAL_MIN) begin
            return 32'h8000_0000;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return DATA_W'($urandom_range(0, 1 << 19) - (1 << 18));
        end
        if (r < 80) begin
            return $urandom;
        end
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            4: return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic longint round_q(input longint p);
        return (p + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint slope(input logic [IDX_W-1:0] dir, a, b, c);
        longint diff;
        diff = longint'(plus_tab[{dir, a, b, c}]) - longint'(minus_tab[{dir, a, b, c}]);
        return round_q(diff * longint'(inv_reg));
    endfunction

    function automatic longint gamma_product(input logic [IDX_W-1:0] a, b, c, d, e, f);
        return round_q(longint'(base_tab[{a, b, c}]) * longint'(base_tab[{d, e, f}]));
    endfunction

    function automatic t_component riemann_component(
        input logic [IDX_W-1:0] rho, sigma, mu, nu
    );
        longint           sum;
        logic [IDX_W-1:0] lam;
        t_component       r;
        sum = slope(mu, rho, nu, sigma) - slope(nu, rho, mu, sigma);
        for (int l = 0; l < DIMS; l++) begin
            lam = IDX_W'(l);
            sum += gamma_product(rho, mu, lam, lam, nu, sigma);
            sum -= gamma_product(rho, nu, lam, lam, mu, sigma);
        end
        r.saturated = 1'b0;
        if (sum > Q_MAX) begin
            sum = Q_MAX;
            r.saturated = 1'b1;
        end else if (sum < Q_MIN) begin
            sum = Q_MIN;
            r.saturated = 1'b1;
        end
        r.component = DATA_W'(sum);
        return r;
    endfunction

    function automatic void absorb_item(input t_item it);
        case (it.kind)
            KIND_BASE: begin
                base_tab[{it.idx_a, it.idx_b, it.idx_c}] = it.entry_value;
            end
            KIND_PLUS: begin
                plus_tab[{it.shift_dir, it.idx_a, it.idx_b, it.idx_c}] = it.entry_value;
            end
            KIND_MINUS: begin
                minus_tab[{it.shift_dir, it.idx_a, it.idx_b, it.idx_c}] = it.entry_value;
            end
            default: begin
                expected_components.push_back(
                    riemann_component(it.idx_a, it.idx_b, it.idx_c, it.idx_d));
            end
        endcase
    endfunction

    function automatic void push_load(
        input t_kind kind,
        input logic [IDX_W-1:0] dir, a, b, c,
        input logic [DATA_W-1:0] value
    );
        t_item it;
        it.kind        = kind;
        it.shift_dir   = dir;
        it.idx_a       = a;
        it.idx_b       = b;
        it.idx_c       = c;
        it.idx_d       = IDX_W'($urandom_range(0, 3));
        it.entry_value = value;
        pending_items.push_back(it);
        items_queued++;
        case (kind)
            KIND_BASE:  base_set[{a, b, c}] = 1'b1;
            KIND_PLUS:  plus_set[{dir, a, b, c}] = 1'b1;
            default:    minus_set[{dir, a, b, c}] = 1'b1;
        endcase
    endfunction

    function automatic void fill_base(input logic [IDX_W-1:0] a, b, c, input t_fill mode);
        if (!base_set[{a, b, c}]) begin
            push_load(KIND_BASE, IDX_W'($urandom_range(0, 3)), a, b, c, pick_value(mode));
        end
    endfunction

    function automatic void fill_shifted(
        input logic [IDX_W-1:0] dir, a, b, c,
        input t_fill plus_mode, minus_mode
    );
        if (!plus_set[{dir, a, b, c}]) begin
            push_load(KIND_PLUS, dir, a, b, c, pick_value(plus_mode));
        end
        if (!minus_set[{dir, a, b, c}]) begin
            push_load(KIND_MINUS, dir, a, b, c, pick_value(minus_mode));
        end
    endfunction

    // Every entry that the query reads is loaded first, unless it already holds a value.
    function automatic void queue_query(
        input logic [IDX_W-1:0] rho, sigma, mu, nu,
        input t_fill base_mode, plus_mode, minus_mode
    );
        logic [IDX_W-1:0] lam;
        t_item            q;
        fill_shifted(mu, rho, nu, sigma, plus_mode, minus_mode);
        fill_shifted(nu, rho, mu, sigma, plus_mode, minus_mode);
        for (int l = 0; l < DIMS; l++) begin
            lam = IDX_W'(l);
            fill_base(rho, mu, lam, base_mode);
            fill_base(lam, nu, sigma, base_mode);
            fill_base(rho, nu, lam, base_mode);
            fill_base(lam, mu, sigma, base_mode);
        end
        q.kind        = KIND_QUERY;
        q.shift_dir   = IDX_W'($urandom_range(0, 3));
        q.idx_a       = rho;
        q.idx_b       = sigma;
        q.idx_c       = mu;
        q.idx_d       = nu;
        q.entry_value = $urandom;
        pending_items.push_back(q);
        items_queued++;
    endfunction

    function automatic logic [IDX_W-1:0] any_index();
        return IDX_W'($urandom_range(0, 3));
    endfunction

    task automatic check_component();
        t_component want;
        if (expected_components.size() == 0) begin
            report_mismatch($sformatf("component %h with no query outstanding",
                                      result_if.component));
        end else begin
            want = expected_components.pop_front();
            if (result_if.component !== want.component) begin
                report_mismatch($sformatf("component %h, expected %h",
                                          result_if.component, want.component));
            end
            if (result_if.saturated !== want.saturated) begin
                report_mismatch($sformatf("saturated %b, expected %b",
                                          result_if.saturated, want.saturated));
            end
        end
    endtask

    task automatic write_inv(input logic [INV_W-1:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready) begin
            @(posedge clk);
        end
        inv_reg = value;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || item_if.valid || expected_components.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            item_if.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                absorb_item(offered);
            end
            if (!item_if.valid || item_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    item_if.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    offered = pending_items.pop_front();
                    item_if.valid       <= 1'b1;
                    item_if.kind        <= offered.kind;
                    item_if.shift_dir   <= offered.shift_dir;
                    item_if.idx_a       <= offered.idx_a;
                    item_if.idx_b       <= offered.idx_b;
                    item_if.idx_c       <= offered.idx_c;
                    item_if.idx_d       <= offered.idx_d;
                    item_if.entry_value <= offered.entry_value;
                    src_gap = src_steady ? 0 : pick_gap();
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                check_component();
                if (!sink_steady) begin
                    sink_gap = pick_gap();
                end
            end else if (sink_gap == 0 && !sink_steady && $urandom_range(0, 7) == 0) begin
                sink_gap = pick_gap();
            end
            result_if.ready <= (sink_gap == 0) && (hold_left == 0);
            if (sink_gap > 0) begin
                sink_gap--;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        logic [INV_W-1:0] inv_plan [6];
        rst_n                 = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.data           = '0;
        hold_req              = 1'b0;
        src_steady            = 1'b0;
        sink_steady           = 1'b0;
        errors                = 0;
        inv_reg               = INV_RESET;
        inv_plan[0] = INV_W'(1);
        inv_plan[1] = 31'h7FFF_FFFF;
        inv_plan[2] = INV_W'(0);
        inv_plan[3] = INV_W'(32768);
        inv_plan[4] = INV_W'($urandom_range(1, 32'h7FFF_FFFF));
        inv_plan[5] = INV_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        queue_query(2'd0, 2'd1, 2'd2, 2'd3, VAL_MAX, VAL_MAX, VAL_MIN);
        queue_query(2'd0, 2'd1, 2'd3, 2'd2, VAL_MAX, VAL_MAX, VAL_MIN);
        queue_query(2'd2, 2'd2, 2'd2, 2'd2, VAL_MIN, VAL_MIN, VAL_MAX);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            write_inv(inv_plan[p]);
            @(negedge clk);
            src_steady   = (p == 3);
            sink_steady  = (p == 4);
            items_queued = 0;
            while (items_queued < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 75) begin
                    queue_query(any_index(), any_index(), any_index(), any_index(),
                                VAL_MIX, VAL_MIX, VAL_MIX);
                end else begin
                    push_load(t_kind'($urandom_range(0, 2)), any_index(), any_index(),
                              any_index(), any_index(), pick_value(VAL_MIX));
                end
            end
            if (p == 1) begin
                // The sink holds off here while the source keeps offering beats.
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("riemann_tensor_component_unit_test OK");
        end else begin
            $display("riemann_tensor_component_unit_test NOT OK");
        end
        $finish;
    end

endmodule
